// ===== src/quaternion_to_euler_angles_defines.svh =====
// Assertion macros for the quaternion to Euler angles block.
// Used by the port checker; depends on nothing else.
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

`define Q2E_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define Q2E_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/q2e_pkg.sv =====
// Shared constants and fixed-point helpers for the quaternion to Euler angles block.
// Used by the CORDIC cell and the top level; depends on nothing.
package q2e_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 14;
    localparam int ATAN_LEN          = 24;
    localparam int SQRT_BITS         = 29;
    localparam int QW                = 16;
    localparam int PW                = 32;
    localparam int SW                = 34;
    localparam int SSW               = 30;
    localparam int XW                = 36;

    localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
    localparam logic signed [31:0] PI_Q13      = 32'sd25736;
    localparam logic signed [31:0] HALF_PI_Q13 = 32'sd12868;
    localparam logic signed [SW-1:0] ONE_Q28   = SW'(64'sd268435456);

    localparam logic [30:0] ATAN_Q30 [ATAN_LEN] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
        31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
        31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
        31'd262144,    31'd131072,    31'd65536,     31'd32768,
        31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128
    };

    function automatic logic signed [31:0] rnd_shift(logic signed [31:0] v, int s);
        logic signed [31:0] half;
        logic signed [31:0] r;
        if (s == 0)
        begin
            r = v;
        end
        else
        begin
            half = 32'sd1 <<< (s - 1);
            if (v < 0)
            begin
                r = -((-v + half) >>> s);
            end
            else
            begin
                r = (v + half) >>> s;
            end
        end
        return r;
    endfunction

    function automatic logic signed [31:0] atan_step(int idx, int frac);
        return rnd_shift($signed({1'b0, ATAN_Q30[idx]}), 30 - frac);
    endfunction

    function automatic logic signed [31:0] half_pi(int frac);
        return rnd_shift(HALF_PI_Q30, 30 - frac);
    endfunction

    function automatic logic signed [31:0] to_q13(logic signed [31:0] a, int frac);
        logic signed [31:0] r;
        if (frac >= 13)
        begin
            r = rnd_shift(a, frac - 13);
        end
        else
        begin
            r = a <<< (13 - frac);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat(logic signed [31:0] v,
                                               logic signed [31:0] lim);
        logic signed [31:0] r;
        if (v > lim)
        begin
            r = lim;
        end
        else if (v < -lim)
        begin
            r = -lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== src/q2e_sqrt_cell.sv =====
// One registered step of the restoring integer square root: one root bit per cell.
// Stand-alone; depends on nothing.
module q2e_sqrt_cell #(
    parameter int SQ = 29
) (
    input  logic            clk,
    input  logic [2*SQ-1:0] rad_in,
    input  logic [SQ+1:0]   rem_in,
    input  logic [SQ-1:0]   root_in,
    output logic [2*SQ-1:0] rad_out,
    output logic [SQ+1:0]   rem_out,
    output logic [SQ-1:0]   root_out
);

    logic [SQ+3:0] rem_try;
    logic [SQ+3:0] trial;
    logic          take;

    always_comb
    begin
        rem_try = {rem_in, rad_in[2*SQ-1:2*SQ-2]};
        trial   = {2'b00, root_in, 2'b01};
        take    = (rem_try >= trial);
    end

    always_ff @(posedge clk)
    begin
        rad_out <= {rad_in[2*SQ-3:0], 2'b00};
        if (take)
        begin
            rem_out  <= (SQ+2)'(rem_try - trial);
            root_out <= {root_in[SQ-2:0], 1'b1};
        end
        else
        begin
            rem_out  <= rem_try[SQ+1:0];
            root_out <= {root_in[SQ-2:0], 1'b0};
        end
    end

endmodule

// ===== src/q2e_cordic_cell.sv =====
// One registered micro-rotation of a vectoring CORDIC.
// Depends on q2e_pkg for the arctangent step.
module q2e_cordic_cell #(
    parameter int XW    = 36,
    parameter int AW    = 17,
    parameter int STAGE = 0,
    parameter int FRAC  = 14
) (
    input  logic                 clk,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [AW-1:0] ang_in,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [AW-1:0] ang_out
);

    localparam logic signed [AW-1:0] DA = AW'(q2e_pkg::atan_step(STAGE, FRAC));

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    assign dx = y_in >>> STAGE;
    assign dy = x_in >>> STAGE;

    always_ff @(posedge clk)
    begin
        if (y_in > 0)
        begin
            x_out   <= x_in + dx;
            y_out   <= y_in - dy;
            ang_out <= ang_in + DA;
        end
        else
        begin
            x_out   <= x_in - dx;
            y_out   <= y_in + dy;
            ang_out <= ang_in - DA;
        end
    end

endmodule

// ===== src/quaternion_to_euler_angles.sv =====
// Top level: quaternion to roll, pitch and yaw through a square-root cell row
// and three CORDIC cell rows. Depends on q2e_pkg, q2e_sqrt_cell, q2e_cordic_cell.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+---------------------
//  command  | quat_x, quat_y, quat_z, quat_w            | start, busy
//  result   | roll_angle, pitch_angle, yaw_angle        | done (one cycle)
//
// One transaction per cycle; busy stays low.
// The pipeline: four product and sum stages, 29 square-root cells, one pre-rotation
// stage, the CORDIC cells and the output register.
// Reset clears the valid pipeline; in-flight transactions are dropped.
// The receiver cannot stall; done is high for exactly one cycle per result.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = q2e_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output logic               done,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle
);

    localparam int SQ      = q2e_pkg::SQRT_BITS;
    localparam int PW      = q2e_pkg::PW;
    localparam int SW      = q2e_pkg::SW;
    localparam int SSW     = q2e_pkg::SSW;
    localparam int XW      = q2e_pkg::XW;
    localparam int AW      = FRAC_BITS + 3;
    localparam int DLY     = SQ + 2;
    localparam int LATENCY = 6 + SQ + CORDIC_STAGES;
    localparam logic signed [AW-1:0] HP = AW'(q2e_pkg::half_pi(FRAC_BITS));
    localparam logic [2*SQ-1:0] ONE_Q56 = (2*SQ)'(1) << 56;

    logic                 accept;
    logic [LATENCY-1:0]   vld_reg;

    logic signed [PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] wz_reg, xy_reg, wy_reg, zx_reg;

    logic signed [SW-1:0] rn_next, rd_next, yn_next, yd_next, s_raw;
    logic signed [SSW-1:0] s_next;
    logic signed [SW-1:0] rn_reg, rd_reg, yn_reg, yd_reg;
    logic signed [SSW-1:0] s_reg;

    logic [2*SSW-1:0]     sq_reg;
    logic [2*SQ-1:0]      rad_reg;

    logic signed [SW-1:0]  rn_dly [DLY];
    logic signed [SW-1:0]  rd_dly [DLY];
    logic signed [SW-1:0]  yn_dly [DLY];
    logic signed [SW-1:0]  yd_dly [DLY];
    logic signed [SSW-1:0] s_dly  [DLY];

    logic [2*SQ-1:0] rad_c  [SQ+1];
    logic [SQ+1:0]   rem_c  [SQ+1];
    logic [SQ-1:0]   root_c [SQ+1];

    logic signed [XW-1:0] pre_x [3];
    logic signed [XW-1:0] pre_y [3];
    logic signed [XW-1:0] rot_x_next [3];
    logic signed [XW-1:0] rot_y_next [3];
    logic signed [AW-1:0] rot_a_next [3];
    logic [2:0]           zero_next;

    logic signed [XW-1:0] cx [3][CORDIC_STAGES+1];
    logic signed [XW-1:0] cy [3][CORDIC_STAGES+1];
    logic signed [AW-1:0] ca [3][CORDIC_STAGES+1];
    logic [2:0]           zero_dly [CORDIC_STAGES+1];

    logic signed [31:0]   roll_q, pitch_q, yaw_q;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign done   = vld_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        wx_reg <= quat_w * quat_x;
        yz_reg <= quat_y * quat_z;
        xx_reg <= quat_x * quat_x;
        yy_reg <= quat_y * quat_y;
        zz_reg <= quat_z * quat_z;
        wz_reg <= quat_w * quat_z;
        xy_reg <= quat_x * quat_y;
        wy_reg <= quat_w * quat_y;
        zx_reg <= quat_z * quat_x;
    end

    always_comb
    begin
        rn_next = (SW'(wx_reg) + SW'(yz_reg)) <<< 1;
        rd_next = q2e_pkg::ONE_Q28 - ((SW'(xx_reg) + SW'(yy_reg)) <<< 1);
        yn_next = (SW'(wz_reg) + SW'(xy_reg)) <<< 1;
        yd_next = q2e_pkg::ONE_Q28 - ((SW'(yy_reg) + SW'(zz_reg)) <<< 1);
        s_raw   = (SW'(wy_reg) - SW'(zx_reg)) <<< 1;
        if (s_raw > q2e_pkg::ONE_Q28)
        begin
            s_next = SSW'(q2e_pkg::ONE_Q28);
        end
        else if (s_raw < -q2e_pkg::ONE_Q28)
        begin
            s_next = SSW'(-q2e_pkg::ONE_Q28);
        end
        else
        begin
            s_next = SSW'(s_raw);
        end
    end

    always_ff @(posedge clk)
    begin
        rn_reg  <= rn_next;
        rd_reg  <= rd_next;
        yn_reg  <= yn_next;
        yd_reg  <= yd_next;
        s_reg   <= s_next;
        sq_reg  <= $unsigned((2*SSW)'(s_reg) * (2*SSW)'(s_reg));
        rad_reg <= ONE_Q56 - (2*SQ)'(sq_reg);
        rn_dly[0] <= rn_reg;
        rd_dly[0] <= rd_reg;
        yn_dly[0] <= yn_reg;
        yd_dly[0] <= yd_reg;
        s_dly[0]  <= s_reg;
        for (int i = 1; i < DLY; i++)
        begin
            rn_dly[i] <= rn_dly[i-1];
            rd_dly[i] <= rd_dly[i-1];
            yn_dly[i] <= yn_dly[i-1];
            yd_dly[i] <= yd_dly[i-1];
            s_dly[i]  <= s_dly[i-1];
        end
    end

    assign rad_c[0]  = rad_reg;
    assign rem_c[0]  = '0;
    assign root_c[0] = '0;

    for (genvar i = 0; i < SQ; i++)
    begin : g_sqrt
        q2e_sqrt_cell #(.SQ(SQ)) u_cell (
            .clk      (clk),
            .rad_in   (rad_c[i]),
            .rem_in   (rem_c[i]),
            .root_in  (root_c[i]),
            .rad_out  (rad_c[i+1]),
            .rem_out  (rem_c[i+1]),
            .root_out (root_c[i+1])
        );
    end

    always_comb
    begin
        pre_y[0] = XW'(rn_dly[DLY-1]);
        pre_x[0] = XW'(rd_dly[DLY-1]);
        pre_y[1] = XW'(s_dly[DLY-1]);
        pre_x[1] = XW'({1'b0, root_c[SQ]});
        pre_y[2] = XW'(yn_dly[DLY-1]);
        pre_x[2] = XW'(yd_dly[DLY-1]);
        for (int ch = 0; ch < 3; ch++)
        begin
            zero_next[ch] = (pre_x[ch] == '0) && (pre_y[ch] == '0);
            rot_x_next[ch] = pre_x[ch];
            rot_y_next[ch] = pre_y[ch];
            rot_a_next[ch] = '0;
            if (pre_x[ch] < 0)
            begin
                if (pre_y[ch] >= 0)
                begin
                    rot_x_next[ch] = pre_y[ch];
                    rot_y_next[ch] = -pre_x[ch];
                    rot_a_next[ch] = HP;
                end
                else
                begin
                    rot_x_next[ch] = -pre_y[ch];
                    rot_y_next[ch] = pre_x[ch];
                    rot_a_next[ch] = -HP;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            cx[ch][0] <= rot_x_next[ch];
            cy[ch][0] <= rot_y_next[ch];
            ca[ch][0] <= rot_a_next[ch];
        end
        zero_dly[0] <= zero_next;
        for (int i = 1; i <= CORDIC_STAGES; i++)
        begin
            zero_dly[i] <= zero_dly[i-1];
        end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_rot
            q2e_cordic_cell #(
                .XW    (XW),
                .AW    (AW),
                .STAGE (i),
                .FRAC  (FRAC_BITS)
            ) u_cell (
                .clk     (clk),
                .x_in    (cx[ch][i]),
                .y_in    (cy[ch][i]),
                .ang_in  (ca[ch][i]),
                .x_out   (cx[ch][i+1]),
                .y_out   (cy[ch][i+1]),
                .ang_out (ca[ch][i+1])
            );
        end
    end

    always_comb
    begin
        roll_q  = q2e_pkg::sat(q2e_pkg::to_q13(32'(ca[0][CORDIC_STAGES]), FRAC_BITS),
                               q2e_pkg::PI_Q13);
        pitch_q = q2e_pkg::sat(q2e_pkg::to_q13(32'(ca[1][CORDIC_STAGES]), FRAC_BITS),
                               q2e_pkg::HALF_PI_Q13);
        yaw_q   = q2e_pkg::sat(q2e_pkg::to_q13(32'(ca[2][CORDIC_STAGES]), FRAC_BITS),
                               q2e_pkg::PI_Q13);
    end

    always_ff @(posedge clk)
    begin
        roll_angle  <= zero_dly[CORDIC_STAGES][0] ? '0 : roll_q[15:0];
        pitch_angle <= zero_dly[CORDIC_STAGES][1] ? '0 : pitch_q[14:0];
        yaw_angle   <= zero_dly[CORDIC_STAGES][2] ? '0 : yaw_q[15:0];
    end

endmodule

// ===== src/q2e_checker.sv =====
// Port checker for the quaternion to Euler angles block, bound to the top level.
// Depends on quaternion_to_euler_angles_defines.svh.
`include "quaternion_to_euler_angles_defines.svh"

module q2e_checker #(
    parameter int LATENCY = 51
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] roll_angle,
    input logic signed [14:0] pitch_angle,
    input logic signed [15:0] yaw_angle
);

    `Q2E_ASSERT_IMP(a_busy_low, 1'b1, !busy, "busy raised")
    `Q2E_ASSERT_IMP(a_done_source, done, $past(start, LATENCY), "result without transaction")
    `Q2E_ASSERT_IMP(a_pitch_range, done,
        (pitch_angle <= 15'sd12868) && (pitch_angle >= -15'sd12868), "pitch out of range")
    `Q2E_ASSERT_IMP(a_roll_yaw_range, done,
        (roll_angle <= 16'sd25736) && (roll_angle >= -16'sd25736) &&
        (yaw_angle <= 16'sd25736) && (yaw_angle >= -16'sd25736), "roll or yaw out of range")
    `Q2E_ASSERT_IMP(a_done_pulse, start && !busy, ##LATENCY done, "transaction lost")

endmodule

bind quaternion_to_euler_angles q2e_checker #(.LATENCY(LATENCY)) u_q2e_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle)
);

// ===== tb/tb.sv =====
// Self-checking testbench for quaternion_to_euler_angles: random and directed quaternions,
// expected angles from a fixed-point CORDIC predictor. Depends on the block only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } quat_t;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } euler_t;

    localparam int STAGES  = 16;
    localparam int FRAC    = 14;
    localparam longint ONE = 64'sd268435456;
    localparam int IDLE_LIMIT = 2000;

    localparam longint ATAN_TAB [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
        8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128};

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic done;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;

    quat_t  pending_quats[$];
    euler_t expected_angles[$];
    int     errors;
    int     idle_cycles;
    int     gap_left;
    bit     stim_done;
    bit     hold_off;
    bit     gaps_on;

    quaternion_to_euler_angles dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle)
    );

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0)
        begin
            return v >>> s;
        end
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint round_shr(longint v, int s);
        longint half;
        if (s == 0)
        begin
            return v;
        end
        half = 64'sd1 <<< (s - 1);
        if (v < 0)
        begin
            return -(((-v) + half) >>> s);
        end
        return (v + half) >>> s;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint ang;
        longint t;
        longint dx;
        longint dy;
        longint da;
        ang = 0;
        if (x == 0 && y == 0)
        begin
            return 0;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                ang = round_shr(64'sd1686629713, 30 - FRAC);
            end
            else
            begin
                x = -y;
                y = t;
                ang = -round_shr(64'sd1686629713, 30 - FRAC);
            end
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            da = round_shr(ATAN_TAB[i], 30 - FRAC);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                ang += da;
            end
            else
            begin
                x -= dx;
                y += dy;
                ang -= da;
            end
        end
        return ang;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b >>= 2;
        end
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
            begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic euler_t predict_angles(quat_t q);
        longint x, y, z, w, rn, rd, yn, yd, s, c;
        euler_t e;
        x = q.x;
        y = q.y;
        z = q.z;
        w = q.w;
        rn = 2 * (w * x + y * z);
        rd = ONE - 2 * (x * x + y * y);
        yn = 2 * (w * z + x * y);
        yd = ONE - 2 * (y * y + z * z);
        s = clamp_sym(2 * (w * y - z * x), ONE);
        c = floor_sqrt(longint'(ONE * ONE - s * s));
        e.roll  = 16'(clamp_sym(round_shr(vector_angle(rn, rd), FRAC - 13), 25736));
        e.pitch = 15'(clamp_sym(round_shr(vector_angle(s, c), FRAC - 13), 12868));
        e.yaw   = 16'(clamp_sym(round_shr(vector_angle(yn, yd), FRAC - 13), 25736));
        return e;
    endfunction

    function automatic logic signed [15:0] rand_comp(bit extreme);
        if (extreme)
        begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic add_quat(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic signed [15:0] w);
        quat_t q;
        q.x = x;
        q.y = y;
        q.z = z;
        q.w = w;
        pending_quats.push_back(q);
    endtask

    task automatic add_unit_quat();
        real a, b, c, d, n;
        a = real'(int'($urandom_range(0, 20000)) - 10000);
        b = real'(int'($urandom_range(0, 20000)) - 10000);
        c = real'(int'($urandom_range(0, 20000)) - 10000);
        d = real'(int'($urandom_range(0, 20000)) - 10000);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
        begin
            n = 1.0;
            d = 1.0;
        end
        add_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                 16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start  <= 1'b0;
            quat_x <= '0;
            quat_y <= '0;
            quat_z <= '0;
            quat_w <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_angles.push_back(predict_angles(pending_quats.pop_front()));
            end
            if (start && busy)
            begin
                start <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (gaps_on && !hold_off && pending_quats.size() > 0
                     && $urandom_range(0, 5) == 0)
            begin
                start <= 1'b0;
                gap_left <= $urandom_range(0, 6);
            end
            else if (!hold_off && pending_quats.size() > 0)
            begin
                start  <= 1'b1;
                quat_x <= pending_quats[0].x;
                quat_y <= pending_quats[0].y;
                quat_z <= pending_quats[0].z;
                quat_w <= pending_quats[0].w;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_angles.size() == 0)
            begin
                $error("unexpected transaction: roll %0d pitch %0d yaw %0d",
                       roll_angle, pitch_angle, yaw_angle);
                errors++;
            end
            else
            begin
                if (roll_angle !== expected_angles[0].roll)
                begin
                    $error("roll_angle: expected %0d, actual %0d",
                           expected_angles[0].roll, roll_angle);
                    errors++;
                end
                if (pitch_angle !== expected_angles[0].pitch)
                begin
                    $error("pitch_angle: expected %0d, actual %0d",
                           expected_angles[0].pitch, pitch_angle);
                    errors++;
                end
                if (yaw_angle !== expected_angles[0].yaw)
                begin
                    $error("yaw_angle: expected %0d, actual %0d",
                           expected_angles[0].yaw, yaw_angle);
                    errors++;
                end
                void'(expected_angles.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        hold_off = 1'b0;
        gaps_on = 1'b1;
        rst_n = 1'b0;
        add_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        add_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        add_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        add_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        add_quat(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
        add_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        add_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        add_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
        add_quat(16'sd0, 16'sd11585, 16'sd0, 16'sd11585);
        add_quat(16'sd0, -16'sd11585, 16'sd0, 16'sd11585);
        add_quat(16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192);
        add_quat(16'sd0, 16'sd16384, 16'sd16384, 16'sd0);
        add_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        add_quat(16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
        add_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        add_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        add_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_quats.size() == 0);
        for (int i = 0; i < 1200; i++)
        begin
            if (i == 400)
            begin
                wait (pending_quats.size() == 0);
                hold_off = 1'b1;
                wait (expected_angles.size() == 0);
                hold_off = 1'b0;
            end
            if (i == 1000)
            begin
                wait (pending_quats.size() == 0);
                gaps_on = 1'b0;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                add_unit_quat();
            end
            else
            begin
                add_quat(rand_comp($urandom_range(0, 1)), rand_comp($urandom_range(0, 1)),
                         rand_comp($urandom_range(0, 1)), rand_comp($urandom_range(0, 1)));
            end
            if (pending_quats.size() > 32)
            begin
                wait (pending_quats.size() < 8);
            end
        end
        wait (pending_quats.size() == 0);
        wait (expected_angles.size() == 0);
        repeat (80) @(posedge clk);
        if (errors == 0 && expected_angles.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
